FILE: hdl/pidaw_pkg.sv
// shared types, widths and codes of the pid regulator with anti-windup
// no dependencies; imported by every module of the block

package pidaw_pkg;

	// field and datapath widths
	localparam int SIG_W    = 16;            // setpoint, measured, drive
	localparam int COEF_W   = 32;            // Q16.16 coefficients
	localparam int ACC_W    = 48;            // saturating accumulators
	localparam int FRAC_W   = 16;            // fraction bits of Q.16 values
	localparam int DIFF_W   = SIG_W + 1;     // error and measurement change
	localparam int OPND_W   = ACC_W;         // serial multiplier operand
	localparam int HI_W     = COEF_W + 1;    // multiplier partial sum
	localparam int CNT_W    = $clog2(OPND_W);
	localparam int SUM_W    = 66;            // internal wide sum
	localparam int CLIP_W   = 2;
	localparam int EN_W     = 2;
	localparam int IDX_W    = 3;
	localparam int DATA_W   = 32;

	// term enable bit positions
	localparam int EN_INTEG = 0;
	localparam int EN_DERIV = 1;

	// clip status codes
	localparam logic [CLIP_W-1:0] CLIP_NONE = 2'd0;
	localparam logic [CLIP_W-1:0] CLIP_LOW  = 2'd1;
	localparam logic [CLIP_W-1:0] CLIP_HIGH = 2'd2;

	// register indexes
	typedef enum logic [IDX_W-1:0] {
		REG_KP,
		REG_KI,
		REG_AD,
		REG_BD,
		REG_KW,
		REG_DMIN,
		REG_DMAX,
		REG_EN
	} reg_idx_t;

	// register reset values
	localparam logic signed [SIG_W-1:0] DMIN_RST = 16'sh8000;
	localparam logic signed [SIG_W-1:0] DMAX_RST = 16'sh7fff;

	typedef struct packed {
		logic signed [COEF_W-1:0] kp;
		logic signed [COEF_W-1:0] ki;
		logic signed [COEF_W-1:0] ad;
		logic signed [COEF_W-1:0] bd;
		logic signed [COEF_W-1:0] kw;
		logic signed [SIG_W-1:0]  dmin;
		logic signed [SIG_W-1:0]  dmax;
		logic [EN_W-1:0]          en;
	} cfg_t;

	// control toward the serial multiplier
	typedef struct packed {
		logic start;
		logic long_op;   // 1: 48-bit operand, 0: 17-bit operand
	} mul_req_t;

	// saturate a wide sum to the accumulator range
	function automatic logic signed [ACC_W-1:0] sat48(input logic signed [SUM_W-1:0] x);
		logic [SUM_W-ACC_W:0] top;
		top = x[SUM_W-1:ACC_W-1];
		if ((&top) || !(|top)) begin
			sat48 = x[ACC_W-1:0];
		end else if (x[SUM_W-1]) begin
			sat48 = {1'b1, {(ACC_W-1){1'b0}}};
		end else begin
			sat48 = {1'b0, {(ACC_W-1){1'b1}}};
		end
	endfunction

endpackage

FILE: hdl/pidaw_regs.sv
// configuration register file of the pid regulator
// depends on pidaw_pkg

module pidaw_regs
	import pidaw_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_wen,
	input  logic [IDX_W-1:0]  cfg_index,
	input  logic [DATA_W-1:0] cfg_wdata,
	output cfg_t              cfg
);

	cfg_t cfg_q;

	// register writes by index
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.kp   <= '0;
			cfg_q.ki   <= '0;
			cfg_q.ad   <= '0;
			cfg_q.bd   <= '0;
			cfg_q.kw   <= '0;
			cfg_q.dmin <= DMIN_RST;
			cfg_q.dmax <= DMAX_RST;
			cfg_q.en   <= '0;
		end else if (cfg_wen) begin
			case (reg_idx_t'(cfg_index))
				REG_KP:   cfg_q.kp   <= cfg_wdata[COEF_W-1:0];
				REG_KI:   cfg_q.ki   <= cfg_wdata[COEF_W-1:0];
				REG_AD:   cfg_q.ad   <= cfg_wdata[COEF_W-1:0];
				REG_BD:   cfg_q.bd   <= cfg_wdata[COEF_W-1:0];
				REG_KW:   cfg_q.kw   <= cfg_wdata[COEF_W-1:0];
				REG_DMIN: cfg_q.dmin <= cfg_wdata[SIG_W-1:0];
				REG_DMAX: cfg_q.dmax <= cfg_wdata[SIG_W-1:0];
				REG_EN:   cfg_q.en   <= cfg_wdata[EN_W-1:0];
				default:  cfg_q.en   <= cfg_q.en;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

FILE: hdl/pidaw_mul.sv
// bit-serial signed multiplier: coefficient in parallel, operand one bit a cycle
// depends on pidaw_pkg

module pidaw_mul
	import pidaw_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  mul_req_t                 req,
	input  logic signed [COEF_W-1:0] coef,
	input  logic [OPND_W-1:0]        opnd,
	output logic                     done,
	output logic signed [HI_W-1:0]   prod_hi,   // product shifted right by step count
	output logic [OPND_W-1:0]        prod_lo    // low product bits, msb-aligned
);

	logic                     busy_q;
	logic                     done_q;
	logic [CNT_W-1:0]         cnt_q;
	logic signed [COEF_W-1:0] coef_q;
	logic [OPND_W-1:0]        x_q;
	logic signed [HI_W-1:0]   acc_q;
	logic [OPND_W-1:0]        lo_q;

	logic                     last;
	logic signed [HI_W:0]     addend;
	logic signed [HI_W:0]     step_sum;

	// one partial product per cycle, the sign bit carries negative weight
	assign last = (cnt_q == '0);

	always_comb begin
		if (!x_q[0]) begin
			addend = '0;
		end else if (last) begin
			addend = -{{2{coef_q[COEF_W-1]}}, coef_q};
		end else begin
			addend = {{2{coef_q[COEF_W-1]}}, coef_q};
		end
		step_sum = {acc_q[HI_W-1], acc_q} + addend;
	end

	// load, shift and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= req.long_op ? CNT_W'(OPND_W - 1) : CNT_W'(DIFF_W - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (last) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// datapath shift registers
	always_ff @(posedge clk) begin
		if (req.start) begin
			coef_q <= coef;
			x_q    <= opnd;
			acc_q  <= '0;
			lo_q   <= '0;
		end else if (busy_q) begin
			x_q   <= {1'b0, x_q[OPND_W-1:1]};
			acc_q <= step_sum[HI_W:1];
			lo_q  <= {step_sum[0], lo_q[OPND_W-1:1]};
		end
	end

	assign done    = done_q;
	assign prod_hi = acc_q;
	assign prod_lo = lo_q;

endmodule

FILE: hdl/pidaw_core.sv
// sequencer and accumulators of the pid regulator
// depends on pidaw_pkg; drives one pidaw_mul instance

module pidaw_core
	import pidaw_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  cfg_t                     cfg,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic                     in_mode,
	input  logic signed [SIG_W-1:0]  in_setpoint,
	input  logic signed [SIG_W-1:0]  in_measured,
	output logic                     res_valid,
	input  logic                     res_ready,
	output logic signed [SIG_W-1:0]  res_drive,
	output logic [CLIP_W-1:0]        res_clipped,
	output mul_req_t                 mul_req,
	output logic signed [COEF_W-1:0] mul_coef,
	output logic [OPND_W-1:0]        mul_opnd,
	input  logic                     mul_done,
	input  logic signed [HI_W-1:0]   mul_hi,
	input  logic [OPND_W-1:0]        mul_lo
);

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DPOLE,
		ST_DGAIN,
		ST_PROP,
		ST_SUMI,
		ST_CLAMP,
		ST_DIFF,
		ST_WIND,
		ST_INTEG,
		ST_OUT
	} state_t;

	state_t                    state_q;
	mul_req_t                  mul_req_q;
	logic signed [COEF_W-1:0]  mul_coef_q;
	logic [OPND_W-1:0]         mul_opnd_q;
	logic signed [ACC_W-1:0]   integ_q;
	logic signed [ACC_W-1:0]   deriv_q;
	logic signed [SIG_W-1:0]   prev_q;
	logic signed [SIG_W-1:0]   meas_q;
	logic signed [DIFF_W-1:0]  err_q;
	logic signed [DIFF_W-1:0]  dmeas_q;
	logic signed [SUM_W-1:0]   sum_q;
	logic signed [COEF_W-1:0]  u_q;
	logic [CLIP_W-1:0]         clip_q;

	logic signed [DIFF_W-1:0]  err_w;
	logic signed [DIFF_W-1:0]  dmeas_w;
	logic signed [SUM_W-1:0]   prod_q16;
	logic signed [SUM_W-1:0]   prod_short;
	logic signed [SUM_W-1:0]   integ_ext;
	logic signed [SUM_W-1:0]   deriv_ext;
	logic signed [SUM_W-1:0]   lo_lim;
	logic signed [SUM_W-1:0]   hi_lim;
	logic signed [SUM_W-1:0]   u_ext;

	// error and measurement change of the incoming beat
	assign err_w   = {in_setpoint[SIG_W-1], in_setpoint} - {in_measured[SIG_W-1], in_measured};
	assign dmeas_w = {in_measured[SIG_W-1], in_measured} - {prev_q[SIG_W-1], prev_q};

	// multiplier results: long product floored by 2^16, short product exact
	assign prod_q16   = {mul_hi[HI_W-1], mul_hi, mul_lo[OPND_W-1:FRAC_W]};
	assign prod_short = {{(SUM_W-HI_W-DIFF_W){mul_hi[HI_W-1]}}, mul_hi,
		mul_lo[OPND_W-1:OPND_W-DIFF_W]};

	// sign extensions onto the wide sum
	assign integ_ext = {{(SUM_W-ACC_W){integ_q[ACC_W-1]}}, integ_q};
	assign deriv_ext = {{(SUM_W-ACC_W){deriv_q[ACC_W-1]}}, deriv_q};
	assign lo_lim    = {{(SUM_W-SIG_W-FRAC_W){cfg.dmin[SIG_W-1]}}, cfg.dmin, {FRAC_W{1'b0}}};
	assign hi_lim    = {{(SUM_W-SIG_W-FRAC_W){cfg.dmax[SIG_W-1]}}, cfg.dmax, {FRAC_W{1'b0}}};
	assign u_ext     = {{(SUM_W-COEF_W){u_q[COEF_W-1]}}, u_q};

	// sequencer: at most one multiplication per state, wide adds between them
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			mul_req_q <= '0;
			integ_q   <= '0;
			deriv_q   <= '0;
			prev_q    <= '0;
		end else begin
			mul_req_q.start <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						if (in_mode) begin
							prev_q  <= in_measured;
							integ_q <= '0;
							deriv_q <= '0;
						end else begin
							meas_q  <= in_measured;
							err_q   <= err_w;
							dmeas_q <= dmeas_w;
							mul_req_q.start <= 1'b1;
							if (cfg.en[EN_DERIV]) begin
								mul_req_q.long_op <= 1'b1;
								mul_coef_q <= cfg.ad;
								mul_opnd_q <= deriv_q;
								state_q    <= ST_DPOLE;
							end else begin
								mul_req_q.long_op <= 1'b0;
								mul_coef_q <= cfg.kp;
								mul_opnd_q <= {{(OPND_W-DIFF_W){err_w[DIFF_W-1]}}, err_w};
								state_q    <= ST_PROP;
							end
						end
					end
				end
				ST_DPOLE: begin
					if (mul_done) begin
						sum_q <= prod_q16;
						mul_req_q.start   <= 1'b1;
						mul_req_q.long_op <= 1'b0;
						mul_coef_q <= cfg.bd;
						mul_opnd_q <= {{(OPND_W-DIFF_W){dmeas_q[DIFF_W-1]}}, dmeas_q};
						state_q    <= ST_DGAIN;
					end
				end
				ST_DGAIN: begin
					if (mul_done) begin
						deriv_q <= sat48(sum_q - prod_short);
						mul_req_q.start   <= 1'b1;
						mul_req_q.long_op <= 1'b0;
						mul_coef_q <= cfg.kp;
						mul_opnd_q <= {{(OPND_W-DIFF_W){err_q[DIFF_W-1]}}, err_q};
						state_q    <= ST_PROP;
					end
				end
				ST_PROP: begin
					if (mul_done) begin
						sum_q   <= prod_short + deriv_ext;
						state_q <= ST_SUMI;
					end
				end
				ST_SUMI: begin
					sum_q   <= sum_q + integ_ext;
					state_q <= ST_CLAMP;
				end
				ST_CLAMP: begin
					// high test overrides low test for inverted limits
					if (sum_q > hi_lim) begin
						u_q    <= hi_lim[COEF_W-1:0];
						clip_q <= CLIP_HIGH;
					end else if (sum_q < lo_lim) begin
						u_q    <= lo_lim[COEF_W-1:0];
						clip_q <= CLIP_LOW;
					end else begin
						u_q    <= sum_q[COEF_W-1:0];
						clip_q <= CLIP_NONE;
					end
					state_q <= ST_DIFF;
				end
				ST_DIFF: begin
					if (cfg.en[EN_INTEG]) begin
						mul_req_q.start   <= 1'b1;
						mul_req_q.long_op <= 1'b1;
						mul_coef_q <= cfg.kw;
						mul_opnd_q <= sat48(u_ext - sum_q);
						state_q    <= ST_WIND;
					end else begin
						state_q <= ST_OUT;
					end
				end
				ST_WIND: begin
					if (mul_done) begin
						sum_q <= prod_q16 + integ_ext;
						mul_req_q.start   <= 1'b1;
						mul_req_q.long_op <= 1'b0;
						mul_coef_q <= cfg.ki;
						mul_opnd_q <= {{(OPND_W-DIFF_W){err_q[DIFF_W-1]}}, err_q};
						state_q    <= ST_INTEG;
					end
				end
				ST_INTEG: begin
					if (mul_done) begin
						integ_q <= sat48(sum_q + prod_short);
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (res_ready) begin
						prev_q  <= meas_q;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign in_ready    = (state_q == ST_IDLE);
	assign res_valid   = (state_q == ST_OUT);
	assign res_drive   = u_q[FRAC_W+SIG_W-1:FRAC_W];
	assign res_clipped = clip_q;
	assign mul_req     = mul_req_q;
	assign mul_coef    = mul_coef_q;
	assign mul_opnd    = mul_opnd_q;

endmodule

FILE: hdl/pid_controller_antiwindup.sv
// pid regulator with filtered derivative on the measurement and back-calculation
// anti-windup. one serial multiplier forms the products in turn; a control beat runs
// the enabled derivative, the proportional and the enabled integral steps, and the next
// beat is taken only once its result has entered the output register. an init beat
// gives no result. one result may wait in the output register; arst_n clears state,
// loads reg defaults.

module pid_controller_antiwindup
	import pidaw_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_wen,
	input  logic [IDX_W-1:0]  cfg_index,
	input  logic [DATA_W-1:0] cfg_wdata,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [31:0]       s_tdata,   // setpoint [15:0], measured [31:16]
	input  logic              s_tuser,   // mode [0]
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [15:0]       m_tdata,   // drive [15:0]
	output logic [1:0]        m_tuser    // clipped [1:0]
);

	cfg_t                     cfg;
	mul_req_t                 mul_req;
	logic signed [COEF_W-1:0] mul_coef;
	logic [OPND_W-1:0]        mul_opnd;
	logic                     mul_done;
	logic signed [HI_W-1:0]   mul_hi;
	logic [OPND_W-1:0]        mul_lo;
	logic                     res_valid;
	logic                     res_ready;
	logic signed [SIG_W-1:0]  res_drive;
	logic [CLIP_W-1:0]        res_clipped;
	logic                     m_valid_q;
	logic [SIG_W-1:0]         m_drive_q;
	logic [CLIP_W-1:0]        m_clip_q;

	pidaw_regs u_regs (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wen   (cfg_wen),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	pidaw_mul u_mul (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (mul_req),
		.coef    (mul_coef),
		.opnd    (mul_opnd),
		.done    (mul_done),
		.prod_hi (mul_hi),
		.prod_lo (mul_lo)
	);

	pidaw_core u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg),
		.in_valid    (s_tvalid),
		.in_ready    (s_tready),
		.in_mode     (s_tuser),
		.in_setpoint (s_tdata[SIG_W-1:0]),
		.in_measured (s_tdata[2*SIG_W-1:SIG_W]),
		.res_valid   (res_valid),
		.res_ready   (res_ready),
		.res_drive   (res_drive),
		.res_clipped (res_clipped),
		.mul_req     (mul_req),
		.mul_coef    (mul_coef),
		.mul_opnd    (mul_opnd),
		.mul_done    (mul_done),
		.mul_hi      (mul_hi),
		.mul_lo      (mul_lo)
	);

	// output register, free when empty or being taken
	assign res_ready = !m_valid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (res_valid && res_ready) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			m_drive_q <= res_drive;
			m_clip_q  <= res_clipped;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = m_drive_q;
	assign m_tuser  = m_clip_q;

endmodule
